FILE: hdl/smpq_pkg.sv
package smpq_pkg;

   localparam int unsigned DATA_W = 32;

   typedef logic [1:0] status_code_type;

   localparam status_code_type ST_PUSHED = 2'd0;
   localparam status_code_type ST_POPPED = 2'd1;
   localparam status_code_type ST_EMPTY  = 2'd2;
   localparam status_code_type ST_FULL   = 2'd3;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   // controller to datapath
   typedef struct packed {
      logic            load_req;
      logic            rd_front;
      logic            rd_hole;
      logic            wr_shift;
      logic            wr_value;
      logic            dec_hole;
      logic            push_commit;
      logic            pop_commit;
      logic            set_status;
      status_code_type status_code;
      logic            capture_pop;
      logic            emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic act_pop;
      logic empty;
      logic full;
      logic hole_zero;
      logic shift;
      logic rsp_free;
   } stat_type;

endpackage

FILE: hdl/smpq_if.sv
interface smpq_req_if;
   logic                              valid;
   logic                              ready;
   logic                              action;
   logic signed [smpq_pkg::DATA_W-1:0] push_value;

   modport source (output valid, output action, output push_value, input ready);
   modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface smpq_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        status;
   logic signed [smpq_pkg::DATA_W-1:0] popped_value;

   modport source (output valid, output status, output popped_value, input ready);
   modport sink   (input valid, input status, input popped_value, output ready);
endinterface

FILE: hdl/sorted_min_priority_queue_unit.sv
// sorted min-priority queue of signed 32-bit values, smallest value out first
// req channel: action 0 pushes push_value in sorted order (ahead of equal
// values), action 1 pops the smallest value. every request transaction
// gives exactly one rsp transaction carrying status (pushed, popped, pop on
// empty, push refused when full) and popped_value (zero unless popped).
// one transaction is worked at a time; entries live in a ring in one ram
// with a head pointer, so a pop costs one ram read.
// steps from request accept to result shown:
//   empty pop or refused push: decode sets the status, then finish
//   pop: decode reads the front, pop_wait takes the ram read, then finish
//   push: decode, then push_rd and push_cmp for each held entry not below
//   the value, and the value is written (in push_rd when it goes to the front);
//   each moved entry takes one ram read and one ram write in turn
// a new request is taken as soon as the result is loaded into the
// rsp register, even while that result still waits to be taken.
// reset (synchronous) empties the queue; ram contents need no clearing.
// when the receiver stalls, the result holds in the rsp register and a
// following transaction is worked up to its own result, then waits.
module sorted_min_priority_queue_unit #(
   parameter int unsigned CAPACITY = 128
) (
   input logic        clock,
   input logic        reset,
   smpq_req_if.sink   req,
   smpq_rsp_if.source rsp
);

   smpq_pkg::cmd_type  cmd;
   smpq_pkg::stat_type stat;

   smpq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req.valid),
      .in_ready (req.ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   smpq_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .in_action  (req.action),
      .in_value   (req.push_value),
      .out_valid  (rsp.valid),
      .out_ready  (rsp.ready),
      .out_status (rsp.status),
      .out_value  (rsp.popped_value)
   );

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("request taken while another is in progress");

   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp.valid)
      else $error("result not presented after emit");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_commit |-> !stat.empty)
      else $error("pop committed on empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push_commit |-> !stat.full)
      else $error("push committed on full queue");

endmodule

FILE: hdl/smpq_ram.sv
module smpq_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/smpq_ctrl.sv
module smpq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  smpq_pkg::stat_type  stat,
   output smpq_pkg::cmd_type   cmd
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DECODE   = 3'd1;
   localparam logic [2:0] S_POP_WAIT = 3'd2;
   localparam logic [2:0] S_PUSH_RD  = 3'd3;
   localparam logic [2:0] S_PUSH_CMP = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.act_pop) begin
               if (stat.empty) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = smpq_pkg::ST_EMPTY;
                  state_in        = S_FINISH;
               end else begin
                  cmd.rd_front = 1'b1;
                  state_in     = S_POP_WAIT;
               end
            end else begin
               if (stat.full) begin
                  cmd.set_status  = 1'b1;
                  cmd.status_code = smpq_pkg::ST_FULL;
                  state_in        = S_FINISH;
               end else begin
                  state_in = S_PUSH_RD;
               end
            end
         end
         S_POP_WAIT: begin
            cmd.set_status  = 1'b1;
            cmd.status_code = smpq_pkg::ST_POPPED;
            cmd.capture_pop = 1'b1;
            cmd.pop_commit  = 1'b1;
            state_in        = S_FINISH;
         end
         S_PUSH_RD: begin
            if (stat.hole_zero) begin
               cmd.wr_value    = 1'b1;
               cmd.push_commit = 1'b1;
               cmd.set_status  = 1'b1;
               cmd.status_code = smpq_pkg::ST_PUSHED;
               state_in        = S_FINISH;
            end else begin
               cmd.rd_hole = 1'b1;
               state_in    = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            // entries not below the new value move up one place
            if (stat.shift) begin
               cmd.wr_shift = 1'b1;
               cmd.dec_hole = 1'b1;
               state_in     = S_PUSH_RD;
            end else begin
               cmd.wr_value    = 1'b1;
               cmd.push_commit = 1'b1;
               cmd.set_status  = 1'b1;
               cmd.status_code = smpq_pkg::ST_PUSHED;
               state_in        = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: hdl/smpq_dpath.sv
module smpq_dpath #(
   parameter int unsigned CAPACITY = 128
) (
   input  logic                                clock,
   input  logic                                reset,
   input  smpq_pkg::cmd_type                   cmd,
   output smpq_pkg::stat_type                  stat,
   input  logic                                in_action,
   input  logic signed [smpq_pkg::DATA_W-1:0]  in_value,
   output logic                                out_valid,
   input  logic                                out_ready,
   output smpq_pkg::status_code_type           out_status,
   output logic signed [smpq_pkg::DATA_W-1:0]  out_value
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned SUM_W = IDX_W + 1;

   logic [IDX_W-1:0]                   head_ff;
   logic [IDX_W-1:0]                   head_in;
   logic [CNT_W-1:0]                   count_ff;
   logic [CNT_W-1:0]                   count_in;
   logic [IDX_W-1:0]                   hole_ff;
   logic                               action_ff;
   logic signed [smpq_pkg::DATA_W-1:0] value_ff;
   smpq_pkg::status_code_type          res_status_ff;
   logic signed [smpq_pkg::DATA_W-1:0] res_value_ff;
   logic                               out_valid_ff;
   smpq_pkg::status_code_type          out_status_ff;
   logic signed [smpq_pkg::DATA_W-1:0] out_value_ff;

   logic [IDX_W-1:0]                   rd_logical;
   logic [IDX_W-1:0]                   rd_addr;
   logic [IDX_W-1:0]                   wr_addr;
   logic [smpq_pkg::DATA_W-1:0]        wr_data;
   logic [smpq_pkg::DATA_W-1:0]        rd_data;
   logic                               rd_en;
   logic                               wr_en;

   // logical slot to ring address, the sum stays below twice the depth
   function automatic logic [IDX_W-1:0] ring_addr(input logic [IDX_W-1:0] base,
                                                  input logic [IDX_W-1:0] offs);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, base} + {1'b0, offs};
      if (sum >= SUM_W'(CAPACITY)) begin
         sum = sum - SUM_W'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign rd_en      = cmd.rd_front | cmd.rd_hole;
   assign rd_logical = cmd.rd_hole ? (hole_ff - IDX_W'(1)) : '0;
   assign rd_addr    = ring_addr(head_ff, rd_logical);
   assign wr_en      = cmd.wr_shift | cmd.wr_value;
   assign wr_addr    = ring_addr(head_ff, hole_ff);
   assign wr_data    = cmd.wr_shift ? rd_data : value_ff;

   smpq_ram #(
      .WIDTH (smpq_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign stat.act_pop   = (action_ff == smpq_pkg::ACT_POP);
   assign stat.empty     = (count_ff == '0);
   assign stat.full      = (count_ff == CNT_W'(CAPACITY));
   assign stat.hole_zero = (hole_ff == '0);
   assign stat.shift     = ($signed(rd_data) >= value_ff);
   assign stat.rsp_free  = ~out_valid_ff | out_ready;

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.pop_commit) begin
         head_in  = ring_addr(head_ff, IDX_W'(1));
         count_in = count_ff - CNT_W'(1);
      end else if (cmd.push_commit) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         action_ff <= in_action;
         value_ff  <= in_value;
         hole_ff   <= count_ff[IDX_W-1:0];
      end else if (cmd.dec_hole) begin
         hole_ff <= hole_ff - IDX_W'(1);
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_code;
         res_value_ff  <= cmd.capture_pop ? $signed(rd_data) : '0;
      end
      if (cmd.emit) begin
         out_status_ff <= res_status_ff;
         out_value_ff  <= res_value_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_status = out_status_ff;
   assign out_value  = out_value_ff;

endmodule
